[hdl/dmxtx_pkg.sv]
// shared constants and control types for the dmx512 frame transmitter
`default_nettype none

package dmxtx_pkg;

  // slot store size (1 to 512)
  localparam int SLOT_COUNT = 512;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int ADDR_W  = 9;
  localparam int LEVEL_W = 8;
  localparam int REQ_W   = 2;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 9;

  localparam logic [ADDR_W-1:0] SLOT_MAX = ADDR_W'(SLOT_COUNT - 1);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_TX_ENABLE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LAST_SLOT  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_START_CODE = 2'd2;

  typedef struct packed {
    logic load_req;     // latch the accepted request
    logic sweep_start;  // reset the sweep counter
    logic sweep_step;   // write zero at the sweep counter and advance
    logic sweep_full;   // sweep covers the whole store (power-up clear)
    logic commit;       // finish the request and load the result register
  } dmxtx_cmd_t;

  typedef struct packed {
    logic req_clear;    // latched request is a clear
    logic sweep_last;   // sweep counter sits on its final slot
    logic out_free;     // result register can take a new result
  } dmxtx_stat_t;

endpackage

`default_nettype wire

[hdl/dmxtx_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module dmxtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire                                    clk,
  input  wire                                    we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                       wdata,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/dmxtx_datapath.sv]
// datapath: config registers, frame position, slot store and result register
`default_nettype none

module dmxtx_datapath
  import dmxtx_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [CFG_IW-1:0]    cfg_index,
  input  wire  [CFG_DW-1:0]    cfg_wdata,
  input  wire  [23:0]          in_tdata,
  input  wire  [REQ_W-1:0]     in_tuser,
  input  wire                  out_tready,
  output logic                 out_tvalid,
  output logic [23:0]          out_tdata,
  output logic [1:0]           out_tuser,
  input  dmxtx_cmd_t           cmd,
  output dmxtx_stat_t          stat
);

  localparam logic [1:0] PH_BREAK = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_SLOTS = 2'd2;

  logic                tx_en_r;
  logic [ADDR_W-1:0]   last_slot_r;
  logic [LEVEL_W-1:0]  start_code_r;

  logic [1:0]          phase_r, phase_nxt;
  logic [ADDR_W-1:0]   slot_idx_r, slot_idx_nxt;
  logic [ADDR_W-1:0]   sweep_r;

  logic [REQ_W-1:0]    req_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [LEVEL_W-1:0]  level_r;

  logic                out_valid_r;
  logic                byte_valid_r, byte_valid_nxt;
  logic [LEVEL_W-1:0]  line_byte_r, line_byte_nxt;
  logic                slow_r, slow_nxt;
  logic [LEVEL_W-1:0]  rlevel_r, rlevel_nxt;
  logic                err_r, err_nxt;

  logic [ADDR_W-1:0]   eff_last;
  logic [ADDR_W-1:0]   sweep_end;
  logic                addr_bad;
  logic                restart;

  logic                ram_we;
  logic [SLOT_AW-1:0]  ram_waddr;
  logic [LEVEL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LEVEL_W-1:0]  ram_rdata;

  assign eff_last  = (last_slot_r > SLOT_MAX) ? SLOT_MAX : last_slot_r;
  assign sweep_end = cmd.sweep_full ? SLOT_MAX : eff_last;
  assign addr_bad  = addr_r > eff_last;
  // slot limit lowered below the running index: send a break instead
  assign restart   = (phase_r == PH_SLOTS) && (slot_idx_r > eff_last);

  assign stat.req_clear  = req_r == REQ_CLEAR;
  assign stat.sweep_last = sweep_r == sweep_end;
  assign stat.out_free   = !out_valid_r || out_tready;

  // read address stays put from accept until commit
  assign rd_addr = (req_r == REQ_TICK) ? slot_idx_r : addr_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r[SLOT_AW-1:0];
    ram_wdata = '0;
    if (cmd.sweep_step) begin
      ram_we = 1'b1;
    end else if (cmd.commit && req_r == REQ_WRITE && !addr_bad) begin
      ram_we    = 1'b1;
      ram_waddr = addr_r[SLOT_AW-1:0];
      ram_wdata = level_r;
    end
  end

  dmxtx_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr[SLOT_AW-1:0]),
    .rdata (ram_rdata)
  );

  // result and next frame position for the latched request
  always_comb begin
    phase_nxt      = phase_r;
    slot_idx_nxt   = slot_idx_r;
    byte_valid_nxt = 1'b0;
    line_byte_nxt  = '0;
    slow_nxt       = 1'b0;
    rlevel_nxt     = '0;
    err_nxt        = 1'b0;
    case (req_r)
      REQ_TICK: begin
        if (!tx_en_r) begin
          phase_nxt    = PH_BREAK;
          slot_idx_nxt = '0;
        end else begin
          byte_valid_nxt = 1'b1;
          if (!restart && phase_r == PH_START) begin
            line_byte_nxt = start_code_r;
            phase_nxt     = PH_SLOTS;
            slot_idx_nxt  = '0;
          end else if (!restart && phase_r == PH_SLOTS) begin
            line_byte_nxt = ram_rdata;
            if (slot_idx_r >= eff_last) begin
              phase_nxt    = PH_BREAK;
              slot_idx_nxt = '0;
            end else begin
              slot_idx_nxt = slot_idx_r + ADDR_W'(1);
            end
          end else begin
            // break, unused phase code or restart
            slow_nxt     = 1'b1;
            phase_nxt    = PH_START;
            slot_idx_nxt = '0;
          end
        end
      end
      REQ_WRITE: begin
        err_nxt = addr_bad;
      end
      REQ_READ: begin
        err_nxt = addr_bad;
        if (!addr_bad) begin
          rlevel_nxt = ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_en_r      <= 1'b0;
      last_slot_r  <= ADDR_W'(511);
      start_code_r <= '0;
      phase_r      <= PH_BREAK;
      slot_idx_r   <= '0;
      sweep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TX_ENABLE:  tx_en_r      <= cfg_wdata[0];
          CFG_LAST_SLOT:  last_slot_r  <= cfg_wdata[ADDR_W-1:0];
          CFG_START_CODE: start_code_r <= cfg_wdata[LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.sweep_start) begin
        sweep_r <= '0;
      end else if (cmd.sweep_step) begin
        sweep_r <= sweep_r + ADDR_W'(1);
      end
      if (cmd.commit) begin
        phase_r     <= phase_nxt;
        slot_idx_r  <= slot_idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_tuser;
      addr_r  <= in_tdata[ADDR_W-1:0];
      level_r <= in_tdata[ADDR_W+LEVEL_W-1:ADDR_W];
    end
    if (cmd.commit) begin
      byte_valid_r <= byte_valid_nxt;
      line_byte_r  <= line_byte_nxt;
      slow_r       <= slow_nxt;
      rlevel_r     <= rlevel_nxt;
      err_r        <= err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, err_r, rlevel_r, line_byte_r};
  assign out_tuser  = {slow_r, byte_valid_r};

endmodule

`default_nettype wire

[hdl/dmxtx_ctrl.sv]
// controller: sequences power-up clear, request handling and slot clears
`default_nettype none

module dmxtx_ctrl
  import dmxtx_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  dmxtx_stat_t  stat,
  output dmxtx_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ISSUE,
    ST_CLEAR,
    ST_FIN
  } state_t;

  state_t state_r;

  assign in_tready = state_r == ST_IDLE;

  always_comb begin
    cmd             = '0;
    cmd.load_req    = (state_r == ST_IDLE) && in_tvalid;
    cmd.sweep_start = state_r == ST_ISSUE;
    cmd.sweep_step  = (state_r == ST_INIT) || (state_r == ST_CLEAR);
    cmd.sweep_full  = state_r == ST_INIT;
    cmd.commit      = (state_r == ST_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      case (state_r)
        ST_INIT: begin
          if (stat.sweep_last) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_ISSUE;
        end
        ST_ISSUE: begin
          // ram read is in flight here
          state_r <= stat.req_clear ? ST_CLEAR : ST_FIN;
        end
        ST_CLEAR: begin
          if (stat.sweep_last) state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (stat.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/dmx512_frame_transmitter.sv]
// dmx512 frame transmitter: slot level store and outgoing frame builder
//
// Input stream: in_tuser carries the request kind (tick, write, read, clear),
// in_tdata the slot address and level. Every request gives exactly one result
// on the output stream: line byte, break flag and byte-valid for ticks, read
// level and address error for slot accesses.
// A tick, write or read goes from the issue state, where the slot store read is
// registered, to the finish state, which loads its result into the output register
// once that register can take it; a clear sweeps zeros into slot store entries 0
// to last_slot in between, one entry written per cycle. One request is in flight
// at a time; the next is taken the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, one more
// request can be taken and worked, then waits until that register frees up.
// After reset the slot store is cleared by a sweep over all its entries during which
// in_tready stays low; configuration writes are taken at any time and must only
// be issued while no request is outstanding.
`default_nettype none

module dmx512_frame_transmitter
  import dmxtx_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [CFG_IW-1:0]  cfg_index,
  input  wire  [CFG_DW-1:0]  cfg_wdata,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [23:0]        in_tdata,   // slot_address[8:0], slot_level[16:9]
  input  wire  [REQ_W-1:0]   in_tuser,   // req_type[1:0]
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [23:0]        out_tdata,  // line_byte[7:0], read_level[15:8], addr_error[16]
  output logic [1:0]         out_tuser   // byte_valid[0], slow_baud[1]
);

  dmxtx_cmd_t  cmd;
  dmxtx_stat_t stat;

  dmxtx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dmxtx_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

`default_nettype wire
